// ===== rtl/rrt_pkg.sv =====
package rrt_pkg;

  localparam int unsigned MaxVerticesDef  = 1024;
  localparam int unsigned MaxObstaclesDef = 64;

  localparam logic [15:0] StartXRst   = 16'd32768;
  localparam logic [15:0] StartYRst   = 16'd6554;
  localparam logic [15:0] GoalXRst    = 16'd32768;
  localparam logic [15:0] GoalYRst    = 16'd58982;
  localparam logic [16:0] StepRngRst  = 17'd3277;
  localparam logic [16:0] GoalRadRst  = 17'd6554;
  localparam logic [15:0] SpacingRst  = 16'd328;
  localparam logic [9:0]  IterLimRst  = 10'd1000;

  localparam logic [2:0] CfgStartX  = 3'd0;
  localparam logic [2:0] CfgStartY  = 3'd1;
  localparam logic [2:0] CfgGoalX   = 3'd2;
  localparam logic [2:0] CfgGoalY   = 3'd3;
  localparam logic [2:0] CfgStepRng = 3'd4;
  localparam logic [2:0] CfgGoalRad = 3'd5;
  localparam logic [2:0] CfgSpacing = 3'd6;
  localparam logic [2:0] CfgIterLim = 3'd7;

  localparam logic [1:0] OpRestart = 2'd0;
  localparam logic [1:0] OpAppend  = 2'd1;
  localparam logic [1:0] OpClear   = 2'd2;
  localparam logic [1:0] OpExtend  = 2'd3;

  localparam logic [2:0] StRestarted = 3'd0;
  localparam logic [2:0] StStored    = 3'd1;
  localparam logic [2:0] StFull      = 3'd2;
  localparam logic [2:0] StCleared   = 3'd3;
  localparam logic [2:0] StCollision = 3'd4;
  localparam logic [2:0] StAdded     = 3'd5;
  localparam logic [2:0] StGoal      = 3'd6;
  localparam logic [2:0] StLimit     = 3'd7;

  // request to / answer from the shared divide and square-root unit
  typedef struct packed {
    logic        start;
    logic        is_sqrt;
    logic [33:0] num;
    logic [16:0] den;
  } alu_req_t;

  typedef struct packed {
    logic        done;
    logic [33:0] quo;
  } alu_rsp_t;

endpackage

// ===== rtl/rrt_alu.sv =====
module rrt_alu (
  input  logic              clk,
  input  logic              rst_n,
  input  rrt_pkg::alu_req_t req,
  output rrt_pkg::alu_rsp_t rsp
);

  logic        busy_r, busy_nxt;
  logic        sq_r, sq_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [33:0] num_r, num_nxt;
  logic [35:0] rem_r, rem_nxt;
  logic [33:0] q_r, q_nxt;
  logic [16:0] den_r, den_nxt;
  logic        done_r, done_nxt;
  logic [35:0] trial;
  logic [35:0] shr;

  always_comb begin
    busy_nxt = busy_r; sq_nxt = sq_r; cnt_nxt = cnt_r; num_nxt = num_r;
    rem_nxt = rem_r; q_nxt = q_r; den_nxt = den_r; done_nxt = 1'b0;
    shr = 36'd0; trial = 36'd0;
    if (req.start) begin
      busy_nxt = 1'b1; sq_nxt = req.is_sqrt; num_nxt = req.num; den_nxt = req.den;
      rem_nxt = 36'd0; q_nxt = 34'd0;
      cnt_nxt = req.is_sqrt ? 6'd17 : 6'd34;
    end else if (busy_r) begin
      if (sq_r) begin
        shr   = {rem_r[33:0], num_r[33:32]};
        trial = {q_r[33:0], 2'b01};
        num_nxt = {num_r[31:0], 2'b00};
        if (shr >= trial) begin
          rem_nxt = shr - trial; q_nxt = {q_r[32:0], 1'b1};
        end else begin
          rem_nxt = shr; q_nxt = {q_r[32:0], 1'b0};
        end
      end else begin
        shr   = {rem_r[34:0], num_r[33]};
        trial = {19'd0, den_r};
        num_nxt = {num_r[32:0], 1'b0};
        if (shr >= trial) begin
          rem_nxt = shr - trial; q_nxt = {q_r[32:0], 1'b1};
        end else begin
          rem_nxt = shr; q_nxt = {q_r[32:0], 1'b0};
        end
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt;
    end
    sq_r <= sq_nxt; cnt_r <= cnt_nxt; num_r <= num_nxt;
    rem_r <= rem_nxt; q_r <= q_nxt; den_r <= den_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quo  = q_r;

endmodule

// ===== rtl/rrt_extend_step_core.sv =====
// Channel | Dir | Fields (low bit first)
// in_     | in  | tdata: operation[1:0] point_x point_y rect_high_x rect_high_y (66 -> 72 bits)
// out_    | out | tdata: status[2:0] new_x new_y new_index parent_index solved (56)
// cfg_    | in  | index[2:0], data[16:0]
// Restart, append, clear: acceptance leads straight to output; ready once result is taken.
// Extend: nearest search reads, squares and compares each stored vertex (one store read
// port), then square roots and divides in the shared unit, two divides per intermediate test
// point, plus a read and a check per obstacle for every test point.
// Synchronous active-low reset sets state, counters, config, vertex 0; stores keep the rest.
// in_tready is low from acceptance until the result has been taken.
module rrt_extend_step_core #(
  parameter int unsigned MAX_VERTICES  = rrt_pkg::MaxVerticesDef,
  parameter int unsigned MAX_OBSTACLES = rrt_pkg::MaxObstaclesDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // operation, point_x, point_y, rect_high_x, rect_high_y
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // status, new_x, new_y, new_index, parent_index, solved
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [16:0] cfg_data
);

  localparam int VW = $clog2(MAX_VERTICES);
  localparam int OW = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1;

  typedef enum logic [4:0] {
    S_IDLE, S_NR_REQ, S_NR_WAIT, S_NR_CMP, S_CLIP_SQ, S_CLIP_SQW, S_CLIP_DX, S_CLIP_DXW,
    S_CLIP_DY, S_CLIP_DYW, S_M_SQ, S_M_SQW, S_TP, S_TP_DX, S_TP_DXW, S_TP_DY, S_TP_DYW,
    S_OB_REQ, S_OB_WAIT, S_OB_CHK, S_COMMIT, S_GOAL, S_OUT
  } state_t;

  state_t state_r;
  logic [15:0] start_x_r, start_y_r, goal_x_r, goal_y_r, spacing_r;
  logic [16:0] range_r, grad_r;
  logic [9:0]  limit_r, attempts_r;
  logic [VW:0] vcount_r;
  logic [OW:0] ocount_r;
  logic        solved_r;

  logic [15:0] vx_mem [MAX_VERTICES];
  logic [15:0] vy_mem [MAX_VERTICES];
  logic [9:0]  vp_mem [MAX_VERTICES];
  logic [63:0] ob_mem [MAX_OBSTACLES];

  logic [1:0]  op_r;
  logic [15:0] px_r, py_r, hx_r, hy_r;
  logic [VW-1:0] vaddr_r, best_r;
  logic [VW:0]   scan_r;
  logic [15:0] rdx_r, rdy_r, nearx_r, neary_r, nx_r, ny_r, tx_r, ty_r;
  logic [33:0] bestd_r, prod_r;
  logic [16:0] den_r;
  logic [17:0] s_r;
  logic [OW-1:0] oaddr_r;
  logic [OW:0]   oscan_r;
  logic [63:0] ob_q_r;
  logic        last_r, hit_r;
  logic [2:0]  status_r;
  logic [9:0]  nidx_r, pidx_r;
  logic [15:0] ox_r, oy_r;
  rrt_pkg::alu_req_t req;
  rrt_pkg::alu_rsp_t rsp;

  rrt_alu u_alu (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp));

  function automatic logic [33:0] sq_sum(input logic [15:0] ax, ay, bx, by);
    logic [15:0] dx, dy;
    dx = (ax >= bx) ? ax - bx : bx - ax;
    dy = (ay >= by) ? ay - by : by - ay;
    return {2'b0, 32'(dx * dx)} + {2'b0, 32'(dy * dy)};
  endfunction

  function automatic logic [15:0] mv(input logic [15:0] a, b, q);
    return (b >= a) ? a + q : a - q;
  endfunction

  logic [15:0] dax, day;
  logic [33:0] r2_r;
  logic [16:0] sp_eff;
  assign dax = (px_r >= nearx_r) ? px_r - nearx_r : nearx_r - px_r;
  assign day = (py_r >= neary_r) ? py_r - neary_r : neary_r - py_r;
  assign sp_eff = (spacing_r == 16'd0) ? 17'd1 : {1'b0, spacing_r};

  assign in_tready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_tvalid = (state_r == S_OUT);
  assign out_tdata = {solved_r, pidx_r, nidx_r, ny_r, nx_r, status_r};

  always_ff @(posedge clk) begin
    req <= '0;
    if (!rst_n) begin
      state_r <= S_IDLE;
      start_x_r <= rrt_pkg::StartXRst; start_y_r <= rrt_pkg::StartYRst;
      goal_x_r <= rrt_pkg::GoalXRst; goal_y_r <= rrt_pkg::GoalYRst;
      range_r <= rrt_pkg::StepRngRst; grad_r <= rrt_pkg::GoalRadRst;
      spacing_r <= rrt_pkg::SpacingRst; limit_r <= rrt_pkg::IterLimRst;
      attempts_r <= 10'd0; vcount_r <= (VW+1)'(1); ocount_r <= '0; solved_r <= 1'b0;
      vx_mem[0] <= rrt_pkg::StartXRst; vy_mem[0] <= rrt_pkg::StartYRst; vp_mem[0] <= 10'd0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          rrt_pkg::CfgStartX:  start_x_r <= cfg_data[15:0];
          rrt_pkg::CfgStartY:  start_y_r <= cfg_data[15:0];
          rrt_pkg::CfgGoalX:   goal_x_r  <= cfg_data[15:0];
          rrt_pkg::CfgGoalY:   goal_y_r  <= cfg_data[15:0];
          rrt_pkg::CfgStepRng: range_r   <= cfg_data;
          rrt_pkg::CfgGoalRad: grad_r    <= cfg_data;
          rrt_pkg::CfgSpacing: spacing_r <= cfg_data[15:0];
          rrt_pkg::CfgIterLim: limit_r   <= cfg_data[9:0];
          default: ;
        endcase
      end
      case (state_r)
        S_IDLE: if (in_tvalid) begin
          op_r <= in_tdata[1:0]; px_r <= in_tdata[17:2]; py_r <= in_tdata[33:18];
          hx_r <= in_tdata[49:34]; hy_r <= in_tdata[65:50];
          nx_r <= '0; ny_r <= '0; nidx_r <= '0; pidx_r <= '0;
          case (in_tdata[1:0])
            rrt_pkg::OpRestart: begin
              vx_mem[0] <= start_x_r; vy_mem[0] <= start_y_r; vp_mem[0] <= 10'd0;
              vcount_r <= (VW+1)'(1); attempts_r <= '0; solved_r <= 1'b0;
              nx_r <= start_x_r; ny_r <= start_y_r;
              status_r <= rrt_pkg::StRestarted; state_r <= S_OUT;
            end
            rrt_pkg::OpAppend: begin
              if (ocount_r < (OW+1)'(MAX_OBSTACLES)) begin
                ob_mem[ocount_r[OW-1:0]] <= {in_tdata[65:50], in_tdata[49:34],
                                             in_tdata[33:18], in_tdata[17:2]};
                ocount_r <= ocount_r + 1'b1; status_r <= rrt_pkg::StStored;
              end else status_r <= rrt_pkg::StFull;
              state_r <= S_OUT;
            end
            rrt_pkg::OpClear: begin
              ocount_r <= '0; status_r <= rrt_pkg::StCleared; state_r <= S_OUT;
            end
            default: begin
              if (attempts_r >= limit_r || vcount_r >= (VW+1)'(MAX_VERTICES)) begin
                solved_r <= 1'b1; status_r <= rrt_pkg::StLimit; state_r <= S_OUT;
              end else begin
                scan_r <= '0; vaddr_r <= '0; state_r <= S_NR_REQ;
              end
            end
          endcase
        end
        S_NR_REQ: begin
          nearx_r <= vx_mem[vaddr_r]; neary_r <= vy_mem[vaddr_r]; state_r <= S_NR_WAIT;
        end
        S_NR_WAIT: begin
          prod_r <= {2'b0, 32'(dax * dax)}; state_r <= S_NR_CMP;
          r2_r <= {2'b0, 32'(day * day)};
        end
        S_NR_CMP: begin
          if (scan_r == '0 || prod_r + r2_r < bestd_r) begin
            bestd_r <= prod_r + r2_r; best_r <= vaddr_r;
          end
          if (scan_r + 1'b1 >= vcount_r) begin
            state_r <= S_CLIP_SQ;
          end else begin
            scan_r <= scan_r + 1'b1; vaddr_r <= vaddr_r + 1'b1; state_r <= S_NR_REQ;
          end
        end
        S_CLIP_SQ: begin
          nearx_r <= vx_mem[best_r]; neary_r <= vy_mem[best_r];
          pidx_r <= 10'(best_r);
          prod_r <= 34'(range_r * range_r);
          state_r <= S_CLIP_SQW;
        end
        S_CLIP_SQW: begin
          if (bestd_r > prod_r) begin
            req.start <= 1'b1; req.is_sqrt <= 1'b1; req.num <= bestd_r;
            state_r <= S_CLIP_DX;
          end else begin
            nx_r <= px_r; ny_r <= py_r; state_r <= S_M_SQ;
          end
        end
        S_CLIP_DX: if (rsp.done) begin
          den_r <= rsp.quo[16:0];
          req.start <= 1'b1; req.is_sqrt <= 1'b0;
          req.num <= 34'(dax * range_r); req.den <= rsp.quo[16:0];
          state_r <= S_CLIP_DXW;
        end
        S_CLIP_DXW: if (rsp.done) begin
          nx_r <= mv(nearx_r, px_r, rsp.quo[15:0]);
          req.start <= 1'b1; req.is_sqrt <= 1'b0;
          req.num <= 34'(day * range_r); req.den <= den_r;
          state_r <= S_CLIP_DYW;
        end
        S_CLIP_DYW: if (rsp.done) begin
          ny_r <= mv(neary_r, py_r, rsp.quo[15:0]); state_r <= S_M_SQ;
        end
        S_M_SQ: begin
          req.start <= 1'b1; req.is_sqrt <= 1'b1;
          req.num <= sq_sum(nearx_r, neary_r, nx_r, ny_r);
          state_r <= S_M_SQW;
        end
        S_M_SQW: if (rsp.done) begin
          den_r <= rsp.quo[16:0]; s_r <= {1'b0, sp_eff}; state_r <= S_TP;
        end
        S_TP: begin
          if (s_r < {1'b0, den_r}) begin
            last_r <= 1'b0;
            req.start <= 1'b1; req.is_sqrt <= 1'b0;
            req.num <= 34'(((nx_r >= nearx_r) ? nx_r - nearx_r : nearx_r - nx_r) * s_r);
            req.den <= den_r;
            state_r <= S_TP_DXW;
          end else begin
            last_r <= 1'b1; tx_r <= nx_r; ty_r <= ny_r;
            oscan_r <= '0; oaddr_r <= '0; hit_r <= 1'b0; state_r <= S_OB_REQ;
          end
        end
        S_TP_DXW: if (rsp.done) begin
          tx_r <= mv(nearx_r, nx_r, rsp.quo[15:0]);
          req.start <= 1'b1; req.is_sqrt <= 1'b0;
          req.num <= 34'(((ny_r >= neary_r) ? ny_r - neary_r : neary_r - ny_r) * s_r);
          req.den <= den_r;
          state_r <= S_TP_DYW;
        end
        S_TP_DYW: if (rsp.done) begin
          ty_r <= mv(neary_r, ny_r, rsp.quo[15:0]);
          oscan_r <= '0; oaddr_r <= '0; hit_r <= 1'b0; state_r <= S_OB_REQ;
        end
        S_OB_REQ: begin
          if (oscan_r >= ocount_r) begin
            if (last_r) state_r <= S_COMMIT;
            else begin
              s_r <= s_r + {1'b0, sp_eff}; state_r <= S_TP;
            end
          end else begin
            ob_q_r <= ob_mem[oaddr_r]; state_r <= S_OB_CHK;
          end
        end
        S_OB_CHK: begin
          if (tx_r >= ob_q_r[15:0] && tx_r < ob_q_r[47:32] &&
              ty_r >= ob_q_r[31:16] && ty_r < ob_q_r[63:48]) begin
            status_r <= rrt_pkg::StCollision; attempts_r <= attempts_r + 1'b1;
            state_r <= S_OUT;
          end else begin
            oscan_r <= oscan_r + 1'b1; oaddr_r <= oaddr_r + 1'b1; state_r <= S_OB_REQ;
          end
        end
        S_COMMIT: begin
          vx_mem[vcount_r[VW-1:0]] <= nx_r; vy_mem[vcount_r[VW-1:0]] <= ny_r;
          vp_mem[vcount_r[VW-1:0]] <= 10'(best_r);
          nidx_r <= 10'(vcount_r); vcount_r <= vcount_r + 1'b1;
          attempts_r <= attempts_r + 1'b1;
          prod_r <= 34'(grad_r * grad_r);
          bestd_r <= sq_sum(nx_r, ny_r, goal_x_r, goal_y_r);
          state_r <= S_GOAL;
        end
        S_GOAL: begin
          if (bestd_r <= prod_r) begin
            solved_r <= 1'b1; status_r <= rrt_pkg::StGoal;
          end else status_r <= rrt_pkg::StAdded;
          state_r <= S_OUT;
        end
        S_OUT: if (out_tready) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/rrt_extend_step_core_chk.sv =====
module rrt_extend_step_core_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [55:0] out_tdata
);

  a_excl: assert property (@(posedge clk) disable iff (!rst_n) !(in_tready && out_tvalid))
    else $error("ready while result pending");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped");
  a_acc: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second transaction taken");
  a_solved: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[2:0] == rrt_pkg::StGoal || out_tdata[2:0] == rrt_pkg::StLimit)
    |-> out_tdata[55])
    else $error("solved flag missing");

endmodule

bind rrt_extend_step_core rrt_extend_step_core_chk u_chk (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
);

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

  typedef struct packed {
    logic       solved;
    logic [9:0] parent_idx;
    logic [9:0] new_idx;
    logic [15:0] new_y;
    logic [15:0] new_x;
    logic [2:0] status;
  } rrt_result_t;

  class rrt_scoreboard;
    logic [15:0] start_x, start_y, goal_x, goal_y, spacing;
    logic [16:0] step_rng, goal_rad;
    logic [9:0]  iter_lim;
    logic [15:0] vx [rrt_pkg::MaxVerticesDef];
    logic [15:0] vy [rrt_pkg::MaxVerticesDef];
    int unsigned n_vert, n_try, n_obs;
    logic [15:0] olx [rrt_pkg::MaxObstaclesDef];
    logic [15:0] oly [rrt_pkg::MaxObstaclesDef];
    logic [15:0] ohx [rrt_pkg::MaxObstaclesDef];
    logic [15:0] ohy [rrt_pkg::MaxObstaclesDef];
    bit          solved;
    rrt_result_t pending_q [$];
    int          errors;

    function new();
      start_x = rrt_pkg::StartXRst; start_y = rrt_pkg::StartYRst;
      goal_x = rrt_pkg::GoalXRst; goal_y = rrt_pkg::GoalYRst;
      step_rng = rrt_pkg::StepRngRst; goal_rad = rrt_pkg::GoalRadRst;
      spacing = rrt_pkg::SpacingRst; iter_lim = rrt_pkg::IterLimRst;
      n_obs = 0; errors = 0;
      regrow();
    endfunction

    function void regrow();
      vx[0] = start_x; vy[0] = start_y;
      n_vert = 1; n_try = 0; solved = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [16:0] val);
      case (idx)
        rrt_pkg::CfgStartX:  start_x = val[15:0];
        rrt_pkg::CfgStartY:  start_y = val[15:0];
        rrt_pkg::CfgGoalX:   goal_x = val[15:0];
        rrt_pkg::CfgGoalY:   goal_y = val[15:0];
        rrt_pkg::CfgStepRng: step_rng = val;
        rrt_pkg::CfgGoalRad: goal_rad = val;
        rrt_pkg::CfgSpacing: spacing = val[15:0];
        default:             iter_lim = val[9:0];
      endcase
    endfunction

    function longint unsigned isqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    function longint unsigned sq_gap(longint unsigned ax, ay, bx, by);
      longint unsigned dx, dy;
      dx = ax >= bx ? ax - bx : bx - ax;
      dy = ay >= by ? ay - by : by - ay;
      return dx * dx + dy * dy;
    endfunction

    function longint unsigned toward(longint unsigned a, b, num, den);
      if (b >= a) return a + (b - a) * num / den;
      return a - (a - b) * num / den;
    endfunction

    function bit hit_point(longint unsigned px, py);
      for (int i = 0; i < n_obs; i++)
        if (px >= olx[i] && px < ohx[i] && py >= oly[i] && py < ohy[i]) return 1;
      return 0;
    endfunction

    function bit edge_blocked(longint unsigned fx, fy, tx, ty);
      longint unsigned m, sp;
      m = isqrt(sq_gap(fx, fy, tx, ty));
      sp = spacing == 0 ? 64'd1 : 64'(spacing);
      for (longint unsigned s = sp; s < m; s += sp)
        if (hit_point(toward(fx, tx, s, m), toward(fy, ty, s, m))) return 1;
      return hit_point(tx, ty);
    endfunction

    function void note_item(logic [71:0] d);
      logic [1:0] op;
      longint unsigned px, py, bestd, dd, nearx, neary, nx, ny, rng;
      int unsigned best;
      rrt_result_t r;
      op = d[1:0]; px = 64'(d[17:2]); py = 64'(d[33:18]);
      r = '0;
      case (op)
        rrt_pkg::OpRestart: begin
          regrow();
          r.status = rrt_pkg::StRestarted; r.new_x = start_x; r.new_y = start_y;
        end
        rrt_pkg::OpAppend: begin
          if (n_obs < rrt_pkg::MaxObstaclesDef) begin
            olx[n_obs] = d[17:2]; oly[n_obs] = d[33:18];
            ohx[n_obs] = d[49:34]; ohy[n_obs] = d[65:50];
            n_obs++;
            r.status = rrt_pkg::StStored;
          end else begin
            r.status = rrt_pkg::StFull;
          end
        end
        rrt_pkg::OpClear: begin
          n_obs = 0;
          r.status = rrt_pkg::StCleared;
        end
        default: begin
          if (n_try >= iter_lim || n_vert >= rrt_pkg::MaxVerticesDef) begin
            solved = 1;
            r.status = rrt_pkg::StLimit;
          end else begin
            best = 0; bestd = 0;
            for (int unsigned i = 0; i < n_vert; i++) begin
              dd = sq_gap(64'(vx[i]), 64'(vy[i]), px, py);
              if (i == 0 || dd < bestd) begin
                bestd = dd; best = i;
              end
            end
            nearx = 64'(vx[best]); neary = 64'(vy[best]);
            rng = 64'(step_rng);
            if (bestd > rng * rng) begin
              dd = isqrt(bestd);
              nx = toward(nearx, px, rng, dd);
              ny = toward(neary, py, rng, dd);
            end else begin
              nx = px; ny = py;
            end
            r.new_x = nx[15:0]; r.new_y = ny[15:0]; r.parent_idx = best[9:0];
            if (edge_blocked(nearx, neary, nx, ny)) begin
              r.status = rrt_pkg::StCollision;
            end else begin
              r.new_idx = n_vert[9:0];
              vx[n_vert] = nx[15:0]; vy[n_vert] = ny[15:0];
              n_vert++;
              rng = 64'(goal_rad);
              if (sq_gap(nx, ny, 64'(goal_x), 64'(goal_y)) <= rng * rng) begin
                solved = 1;
                r.status = rrt_pkg::StGoal;
              end else begin
                r.status = rrt_pkg::StAdded;
              end
            end
            n_try++;
          end
        end
      endcase
      r.solved = solved;
      pending_q.push_back(r);
    endfunction

    function void check_result(logic [55:0] d);
      rrt_result_t a, e;
      a = d;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, d);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      if (a.status !== e.status) begin
        $display("%0t: status exp %0d got %0d", $time, e.status, a.status); errors++;
      end
      if (a.new_x !== e.new_x) begin
        $display("%0t: new_x exp %0d got %0d", $time, e.new_x, a.new_x); errors++;
      end
      if (a.new_y !== e.new_y) begin
        $display("%0t: new_y exp %0d got %0d", $time, e.new_y, a.new_y); errors++;
      end
      if (a.new_idx !== e.new_idx) begin
        $display("%0t: new_index exp %0d got %0d", $time, e.new_idx, a.new_idx); errors++;
      end
      if (a.parent_idx !== e.parent_idx) begin
        $display("%0t: parent_index exp %0d got %0d", $time, e.parent_idx, a.parent_idx);
        errors++;
      end
      if (a.solved !== e.solved) begin
        $display("%0t: solved exp %0d got %0d", $time, e.solved, a.solved); errors++;
      end
    endfunction
  endclass

  logic        clk, rst_n;
  logic        in_tvalid, in_tready;
  logic [71:0] in_tdata;
  logic        out_tvalid, out_tready;
  logic [55:0] out_tdata;
  logic        cfg_valid, cfg_ready;
  logic [2:0]  cfg_index;
  logic [16:0] cfg_data;

  rrt_scoreboard tree_sb;
  bit quiet;
  int stall_left;

  rrt_extend_step_core u_top (.*);

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  initial begin
    #500ms;
    $display("DONE: errors detected");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) tree_sb.note_item(in_tdata);
    if (rst_n && out_tvalid && out_tready) tree_sb.check_result(out_tdata);
  end

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 0;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 2);
      out_tready <= 0;
    end else begin
      out_tready <= 1;
    end
  end

  task automatic send_item(logic [1:0] op, logic [15:0] px, py, hx, hy);
    if (!quiet && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) @(posedge clk);
    @(posedge clk);
    in_tvalid <= 1;
    in_tdata <= {6'b0, hy, hx, py, px, op};
    do @(posedge clk); while (!in_tready);
    in_tvalid <= 0;
  endtask

  task automatic drain();
    @(posedge clk);
    while (tree_sb.pending_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [16:0] val);
    @(posedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    tree_sb.set_reg(idx, val);
  endtask

  task automatic extend(logic [15:0] px, py);
    send_item(rrt_pkg::OpExtend, px, py, 16'($urandom), 16'($urandom));
  endtask

  // random setting, test points per edge kept to at most two dozen
  task automatic random_setting();
    logic [16:0] rng;
    case ($urandom_range(0, 3))
      0: begin rng = 17'd131071; write_reg(rrt_pkg::CfgSpacing, 17'h0FFFF); end
      1: begin rng = 17'd1; write_reg(rrt_pkg::CfgSpacing, 17'd1); end
      default: begin
        rng = 17'($urandom_range(300, 20000));
        write_reg(rrt_pkg::CfgSpacing, 17'(rng / 24 + $urandom_range(1, 2000)));
      end
    endcase
    write_reg(rrt_pkg::CfgStepRng, rng);
    write_reg(rrt_pkg::CfgStartX, 17'($urandom_range(0, 65535)));
    write_reg(rrt_pkg::CfgStartY, 17'($urandom_range(0, 65535)));
    write_reg(rrt_pkg::CfgGoalX, 17'($urandom_range(0, 65535)));
    write_reg(rrt_pkg::CfgGoalY, 17'($urandom_range(0, 65535)));
    write_reg(rrt_pkg::CfgGoalRad,
              $urandom_range(0, 3) == 0 ? 17'd131071 : 17'($urandom_range(1, 20000)));
    write_reg(rrt_pkg::CfgIterLim,
              $urandom_range(0, 3) == 0 ? 17'($urandom_range(0, 12)) : 17'd1023);
  endtask

  task automatic random_phase(int n);
    logic [15:0] ax, ay;
    send_item(rrt_pkg::OpRestart, 16'($urandom), 16'($urandom), 16'($urandom),
              16'($urandom));
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 19))
        0: send_item(rrt_pkg::OpRestart, 16'($urandom), 16'($urandom), 16'($urandom),
                     16'($urandom));
        1: send_item(rrt_pkg::OpClear, 16'($urandom), 16'($urandom), 16'($urandom),
                     16'($urandom));
        2, 3, 4: begin
          ax = 16'($urandom); ay = 16'($urandom);
          send_item(rrt_pkg::OpAppend, ax, ay, 16'(ax + $urandom_range(0, 8000)),
                    16'(ay + $urandom_range(0, 8000)));
        end
        5: send_item(rrt_pkg::OpAppend, 16'($urandom), 16'($urandom), 16'($urandom),
                     16'($urandom));
        default: extend(16'($urandom), 16'($urandom));
      endcase
    end
    drain();
  endtask

  initial begin
    tree_sb = new();
    rst_n = 0; quiet = 0; stall_left = 0;
    in_tvalid = 0; in_tdata = '0; out_tready = 0;
    cfg_valid = 0; cfg_index = rrt_pkg::CfgStartX; cfg_data = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1;

    // defaults: reach toward corners, obstacle hit, empty rectangle, clear
    extend(16'd0, 16'd0);
    extend(16'hFFFF, 16'hFFFF);
    extend(16'd32768, 16'd7000);
    send_item(rrt_pkg::OpAppend, 16'd30000, 16'd8000, 16'd36000, 16'd12000);
    send_item(rrt_pkg::OpAppend, 16'd40000, 16'd0, 16'd40000, 16'hFFFF);
    extend(16'd32768, 16'd11000);
    extend(16'd40000, 16'd5000);
    send_item(rrt_pkg::OpClear, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    extend(16'd32768, 16'd11000);
    drain();

    // nearest-vertex tie, goal reached exactly, extend after goal, then goal with a huge radius
    write_reg(rrt_pkg::CfgStartX, 17'd32768);
    write_reg(rrt_pkg::CfgStartY, 17'd32768);
    write_reg(rrt_pkg::CfgStepRng, 17'd131071);
    write_reg(rrt_pkg::CfgSpacing, 17'h0FFFF);
    write_reg(rrt_pkg::CfgGoalRad, 17'd1);
    write_reg(rrt_pkg::CfgGoalX, 17'd0);
    write_reg(rrt_pkg::CfgGoalY, 17'h0FFFF);
    send_item(rrt_pkg::OpRestart, 16'd0, 16'd0, 16'd0, 16'd0);
    extend(16'd32868, 16'd32768);
    extend(16'd32818, 16'd32768);
    extend(16'd0, 16'hFFFF);
    extend(16'd100, 16'd100);
    drain();
    write_reg(rrt_pkg::CfgGoalRad, 17'd131071);
    extend(16'hFFFF, 16'd0);
    extend(16'd5, 16'd9);
    drain();

    // zero step range, zero spacing, iteration limit of zero
    write_reg(rrt_pkg::CfgStepRng, 17'd0);
    write_reg(rrt_pkg::CfgSpacing, 17'd0);
    extend(16'd1234, 16'd4321);
    drain();
    write_reg(rrt_pkg::CfgStepRng, 17'd20);
    extend(16'd1234, 16'd4321);
    drain();
    write_reg(rrt_pkg::CfgIterLim, 17'd0);
    send_item(rrt_pkg::OpRestart, 16'd0, 16'd0, 16'd0, 16'd0);
    extend(16'd1, 16'd1);
    drain();

    // obstacle table filled past its size
    write_reg(rrt_pkg::CfgIterLim, 17'd1023);
    write_reg(rrt_pkg::CfgSpacing, 17'd200);
    write_reg(rrt_pkg::CfgStepRng, 17'd3000);
    for (int i = 0; i < rrt_pkg::MaxObstaclesDef + 2; i++) begin
      logic [15:0] ax, ay;
      ax = 16'($urandom); ay = 16'($urandom);
      send_item(rrt_pkg::OpAppend, ax, ay, 16'(ax + $urandom_range(0, 3000)),
                16'(ay + $urandom_range(0, 3000)));
    end
    for (int i = 0; i < 6; i++) extend(16'($urandom), 16'($urandom));
    drain();

    for (int p = 0; p < 6; p++) begin
      if (p == 5) quiet = 1;
      random_setting();
      random_phase(7);
    end

    while (tree_sb.pending_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (tree_sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== rrt_extend_step_core.f =====
rtl/rrt_pkg.sv
rtl/rrt_alu.sv
rtl/rrt_extend_step_core.sv
rtl/rrt_extend_step_core_chk.sv
dv/tb_top.sv
